// ----- hdl/two_set_key_table_insert_top_macros.svh -----
// Assertion macros shared by the key table RTL.
`ifndef TWO_SET_KEY_TABLE_INSERT_TOP_MACROS_SVH
`define TWO_SET_KEY_TABLE_INSERT_TOP_MACROS_SVH

// Checked on every rising edge outside reset.
`define TSK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, during reset too.
`define TSK_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/tsk_pkg.sv -----
// Shared constants and types of the two-set key table.
package tsk_pkg;

    localparam int ART_SLOTS    = 256;
    localparam int NONE_ENTRIES = 256;

    localparam int ART_IDX_W  = $clog2(ART_SLOTS);
    localparam int NONE_IDX_W = $clog2(NONE_ENTRIES);
    localparam int ART_CNT_W  = $clog2(ART_SLOTS + 1);
    localparam int NONE_CNT_W = $clog2(NONE_ENTRIES + 1);
    localparam int SCAN_W     = (ART_CNT_W > NONE_CNT_W) ? ART_CNT_W : NONE_CNT_W;

    localparam int HALF_W   = 64;
    localparam int KEY_W    = 2 * HALF_W;
    localparam int STRIDE_W = 20;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 8;

    typedef logic [ART_IDX_W-1:0]  art_idx_t;
    typedef logic [NONE_IDX_W-1:0] none_idx_t;
    typedef logic [ART_CNT_W-1:0]  art_cnt_t;
    typedef logic [NONE_CNT_W-1:0] none_cnt_t;
    typedef logic [SCAN_W-1:0]     scan_t;
    typedef logic [KEY_W-1:0]      key_t;
    typedef logic [STRIDE_W-1:0]   stride_t;
    typedef logic [STATUS_W-1:0]   status_t;
    typedef logic [SLOT_W-1:0]     slot_t;

    localparam art_cnt_t  ART_FULL  = art_cnt_t'(ART_SLOTS);
    localparam none_cnt_t NONE_FULL = none_cnt_t'(NONE_ENTRIES);

    localparam stride_t STRIDE_RESET = stride_t'(12288);

    localparam logic KIND_ART  = 1'b0;
    localparam logic KIND_NONE = 1'b1;

    localparam status_t ST_ART_ADDED   = 3'd0;
    localparam status_t ST_ART_UPDATED = 3'd1;
    localparam status_t ST_NONE_ADDED  = 3'd2;
    localparam status_t ST_IGNORED     = 3'd3;
    localparam status_t ST_BAD_LENGTH  = 3'd4;
    localparam status_t ST_FULL        = 3'd5;

endpackage

// ----- hdl/tsk_req_if.sv -----
// Request channel of the key table: one key to insert per transaction.
interface tsk_req_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic [tsk_pkg::HALF_W-1:0]          key_high;
    logic [tsk_pkg::HALF_W-1:0]          key_low;
    logic [tsk_pkg::STRIDE_W-1:0]        pixel_length;

    modport source (output valid, output kind, output key_high, output key_low,
                    output pixel_length, input ready);
    modport sink   (input valid, input kind, input key_high, input key_low,
                    input pixel_length, output ready);
endinterface

// ----- hdl/tsk_rsp_if.sv -----
// Response channel of the key table: one outcome per transaction.
interface tsk_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tsk_pkg::STATUS_W-1:0]  status;
    logic [tsk_pkg::SLOT_W-1:0]    slot;
    logic                          left_no_art;

    modport source (output valid, output status, output slot, output left_no_art,
                    input ready);
    modport sink   (input valid, input status, input slot, input left_no_art,
                    output ready);
endinterface

// ----- hdl/two_set_key_table_insert_top.sv -----
// Top level of the two-set key table: insert sequencer around two key memories.
//
//   Channel   Kind            Contents
//   req       valid/ready     kind, key_high, key_low, pixel_length
//   rsp       valid/ready     status, slot, left_no_art
//   cfg       write enable    cfg_wr_data is the pixel stride
//
// Each memory is read one entry per cycle behind a registered read, and the block
// takes no new item until the result of the last has moved to the output register.
// Moving later no-art entries down overlaps the scan when an add-art key leaves
// the no-art set. Reset clears only the fill counts and the control state and sets
// the stride to STRIDE_RESET; no clearing pass.
// A finished result waits in the output register while the next item runs.
`include "two_set_key_table_insert_top_macros.svh"

module two_set_key_table_insert_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [tsk_pkg::STRIDE_W-1:0] cfg_wr_data,
    tsk_req_if.sink                   req,
    tsk_rsp_if.source                 rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NSCAN = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_ASCAN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic                kind_reg, kind_next;
    tsk_pkg::key_t       key_reg, key_next;
    logic                left_reg, left_next;
    tsk_pkg::status_t    res_status_reg, res_status_next;
    tsk_pkg::slot_t      res_slot_reg, res_slot_next;
    logic                out_valid_reg, out_valid_next;
    tsk_pkg::status_t    out_status_reg, out_status_next;
    tsk_pkg::slot_t      out_slot_reg, out_slot_next;
    logic                out_left_reg, out_left_next;
    tsk_pkg::art_cnt_t   art_fill_reg, art_fill_next;
    tsk_pkg::none_cnt_t  none_fill_reg, none_fill_next;
    tsk_pkg::stride_t    stride_reg;
    tsk_pkg::scan_t      scan_idx_reg, scan_idx_next;
    logic                pend_reg, pend_next;
    tsk_pkg::scan_t      pend_idx_reg, pend_idx_next;

    logic                art_we;
    tsk_pkg::art_idx_t   art_waddr, art_raddr;
    tsk_pkg::key_t       art_rdata;
    logic                none_we;
    tsk_pkg::none_idx_t  none_waddr, none_raddr;
    tsk_pkg::key_t       none_wdata, none_rdata;

    tsk_pkg::scan_t      scan_fill;
    tsk_pkg::key_t       scan_rdata;
    logic                rd_hit;
    logic                issue;
    logic                scan_miss;

    tsk_ram #(.WIDTH(tsk_pkg::KEY_W), .DEPTH(tsk_pkg::ART_SLOTS)) u_art_ram (
        .clk   (clk),
        .we    (art_we),
        .waddr (art_waddr),
        .wdata (key_reg),
        .raddr (art_raddr),
        .rdata (art_rdata)
    );

    tsk_ram #(.WIDTH(tsk_pkg::KEY_W), .DEPTH(tsk_pkg::NONE_ENTRIES)) u_none_ram (
        .clk   (clk),
        .we    (none_we),
        .waddr (none_waddr),
        .wdata (none_wdata),
        .raddr (none_raddr),
        .rdata (none_rdata)
    );

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.slot        = out_slot_reg;
    assign rsp.left_no_art = out_left_reg;

    // The scan walks the no-art memory in NSCAN and SHIFT, the art memory in ASCAN.
    assign scan_fill  = (state_reg == S_ASCAN) ? tsk_pkg::scan_t'(art_fill_reg)
                                               : tsk_pkg::scan_t'(none_fill_reg);
    assign scan_rdata = (state_reg == S_ASCAN) ? art_rdata : none_rdata;
    assign rd_hit     = pend_reg && (scan_rdata == key_reg);
    assign issue      = (scan_idx_reg < scan_fill);
    assign scan_miss  = !pend_reg && !issue;

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        left_next       = left_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_left_next   = out_left_reg;
        art_fill_next   = art_fill_reg;
        none_fill_next  = none_fill_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;

        art_we     = 1'b0;
        art_waddr  = tsk_pkg::art_idx_t'(art_fill_reg);
        art_raddr  = tsk_pkg::art_idx_t'(scan_idx_reg);
        none_we    = 1'b0;
        none_waddr = tsk_pkg::none_idx_t'(none_fill_reg);
        none_wdata = key_reg;
        none_raddr = tsk_pkg::none_idx_t'(scan_idx_reg);

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next     = req.kind;
                    key_next      = {req.key_high, req.key_low};
                    left_next     = 1'b0;
                    res_slot_next = '0;
                    scan_idx_next = '0;
                    pend_next     = 1'b0;
                    if (req.kind == tsk_pkg::KIND_ART && req.pixel_length != stride_reg)
                    begin
                        res_status_next = tsk_pkg::ST_BAD_LENGTH;
                        state_next      = S_DONE;
                    end
                    else if (req.kind == tsk_pkg::KIND_ART)
                    begin
                        state_next = S_NSCAN;
                    end
                    else
                    begin
                        state_next = S_ASCAN;
                    end
                end
            end

            S_NSCAN:
            begin
                if (rd_hit)
                begin
                    if (kind_reg == tsk_pkg::KIND_ART)
                    begin
                        // Move every later entry down one place to close the gap.
                        left_next     = 1'b1;
                        scan_idx_next = pend_idx_reg + tsk_pkg::scan_t'(1);
                        pend_next     = 1'b0;
                        state_next    = S_SHIFT;
                    end
                    else
                    begin
                        res_status_next = tsk_pkg::ST_IGNORED;
                        state_next      = S_DONE;
                    end
                end
                else if (scan_miss)
                begin
                    if (kind_reg == tsk_pkg::KIND_ART)
                    begin
                        scan_idx_next = '0;
                        state_next    = S_ASCAN;
                    end
                    else if (none_fill_reg == tsk_pkg::NONE_FULL)
                    begin
                        res_status_next = tsk_pkg::ST_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        none_we         = 1'b1;
                        none_fill_next  = none_fill_reg + tsk_pkg::none_cnt_t'(1);
                        res_status_next = tsk_pkg::ST_NONE_ADDED;
                        state_next      = S_DONE;
                    end
                end
                else
                begin
                    pend_next     = issue;
                    pend_idx_next = scan_idx_reg;
                    scan_idx_next = scan_idx_reg + tsk_pkg::scan_t'(1);
                end
            end

            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    none_we    = 1'b1;
                    none_waddr = tsk_pkg::none_idx_t'(pend_idx_reg - tsk_pkg::scan_t'(1));
                    none_wdata = none_rdata;
                end
                if (scan_miss)
                begin
                    none_fill_next = none_fill_reg - tsk_pkg::none_cnt_t'(1);
                    scan_idx_next  = '0;
                    state_next     = S_ASCAN;
                end
                else
                begin
                    pend_next = issue;
                    if (issue)
                    begin
                        pend_idx_next = scan_idx_reg;
                        scan_idx_next = scan_idx_reg + tsk_pkg::scan_t'(1);
                    end
                end
            end

            S_ASCAN:
            begin
                if (rd_hit)
                begin
                    if (kind_reg == tsk_pkg::KIND_ART)
                    begin
                        res_status_next = tsk_pkg::ST_ART_UPDATED;
                        res_slot_next   = tsk_pkg::slot_t'(pend_idx_reg);
                    end
                    else
                    begin
                        res_status_next = tsk_pkg::ST_IGNORED;
                    end
                    state_next = S_DONE;
                end
                else if (scan_miss)
                begin
                    if (kind_reg == tsk_pkg::KIND_NONE)
                    begin
                        scan_idx_next = '0;
                        state_next    = S_NSCAN;
                    end
                    else if (art_fill_reg == tsk_pkg::ART_FULL)
                    begin
                        res_status_next = tsk_pkg::ST_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        art_we          = 1'b1;
                        res_slot_next   = tsk_pkg::slot_t'(art_fill_reg);
                        art_fill_next   = art_fill_reg + tsk_pkg::art_cnt_t'(1);
                        res_status_next = tsk_pkg::ST_ART_ADDED;
                        state_next      = S_DONE;
                    end
                end
                else
                begin
                    pend_next     = issue;
                    pend_idx_next = scan_idx_reg;
                    scan_idx_next = scan_idx_reg + tsk_pkg::scan_t'(1);
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_left_next   = left_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            art_fill_reg  <= '0;
            none_fill_reg <= '0;
            stride_reg    <= tsk_pkg::STRIDE_RESET;
            pend_reg      <= 1'b0;
            scan_idx_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            art_fill_reg  <= art_fill_next;
            none_fill_reg <= none_fill_next;
            pend_reg      <= pend_next;
            scan_idx_reg  <= scan_idx_next;
            if (cfg_wr_en)
            begin
                stride_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        left_reg       <= left_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_left_reg   <= out_left_next;
        pend_idx_reg   <= pend_idx_next;
    end

    `TSK_ASSERT(a_art_fill_bound, art_fill_reg <= tsk_pkg::ART_FULL, "art fill count overflow")
    `TSK_ASSERT(a_art_write_room, art_we |-> (art_fill_reg < tsk_pkg::ART_FULL), "art append while full")
    `TSK_ASSERT(a_none_fill_step, (none_fill_reg != $past(none_fill_reg)) |-> ((none_fill_reg == $past(none_fill_reg) + 1'b1) || (none_fill_reg == $past(none_fill_reg) - 1'b1)), "none fill jumped")
    `TSK_ASSERT(a_slot_zero, (rsp.valid && rsp.status != tsk_pkg::ST_ART_ADDED && rsp.status != tsk_pkg::ST_ART_UPDATED) |-> (rsp.slot == '0), "slot set on non-art result")
    `TSK_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_reg == S_IDLE && !rsp.valid), "not idle after reset")

endmodule

// ----- hdl/tsk_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module tsk_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the two-set key table insert block.
module testbench;

    localparam int TARGET_ITEMS  = 1170;
    localparam int MIX_PHASES    = 4;
    localparam int MIX_ITEMS     = 175;
    localparam int SETTLE_CYCLES = 800;
    localparam int GAP_LIMIT     = 10;
    localparam int RECENT_DEPTH  = 64;

    localparam tsk_pkg::stride_t STRIDE_MIN = tsk_pkg::stride_t'(3);
    localparam tsk_pkg::stride_t STRIDE_MAX = tsk_pkg::stride_t'(786432);

    localparam tsk_pkg::key_t KEY_ZERO      = '0;
    localparam tsk_pkg::key_t KEY_ONES      = '1;
    localparam tsk_pkg::key_t KEY_LOW_ONES  = {{tsk_pkg::HALF_W{1'b0}}, {tsk_pkg::HALF_W{1'b1}}};
    localparam tsk_pkg::key_t KEY_HIGH_ONES = {{tsk_pkg::HALF_W{1'b1}}, {tsk_pkg::HALF_W{1'b0}}};
    localparam tsk_pkg::key_t KEY_BIT0      = tsk_pkg::key_t'(1);

    typedef struct packed {
        tsk_pkg::status_t status;
        tsk_pkg::slot_t   slot;
        logic             left_no_art;
    } outcome_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    tsk_pkg::stride_t cfg_wr_data;

    tsk_req_if req_ch ();
    tsk_rsp_if rsp_ch ();

    two_set_key_table_insert_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // Mirror of both key sets; a queue index is the slot in the block.
    tsk_pkg::key_t    art_keys[$];
    tsk_pkg::key_t    none_keys[$];
    tsk_pkg::key_t    recent_keys[$];
    tsk_pkg::stride_t model_stride;
    outcome_t         pending_outcomes[$];

    int error_count     = 0;
    int requests_sent   = 0;
    int stride_writes   = 0;
    int left_count      = 0;
    int status_seen[8]  = '{default: 0};
    int send_gap_max    = GAP_LIMIT;
    int recv_gap_max    = GAP_LIMIT;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic tsk_pkg::key_t fresh_key();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic outcome_t predict_insert(input logic kind, input tsk_pkg::key_t key,
                                                input tsk_pkg::stride_t plen);
        outcome_t res;
        int       none_pos;
        int       art_pos;
        res      = '{status: tsk_pkg::ST_IGNORED, slot: '0, left_no_art: 1'b0};
        none_pos = -1;
        art_pos  = -1;
        foreach (none_keys[i])
        begin
            if (none_pos < 0 && none_keys[i] == key)
                none_pos = i;
        end
        foreach (art_keys[i])
        begin
            if (art_pos < 0 && art_keys[i] == key)
                art_pos = i;
        end
        if (kind == tsk_pkg::KIND_ART)
        begin
            if (plen != model_stride)
                res.status = tsk_pkg::ST_BAD_LENGTH;
            else
            begin
                // The removal from the no-art set stands even when the art set is full.
                if (none_pos >= 0)
                begin
                    none_keys.delete(none_pos);
                    res.left_no_art = 1'b1;
                end
                if (art_pos >= 0)
                begin
                    res.status = tsk_pkg::ST_ART_UPDATED;
                    res.slot   = tsk_pkg::slot_t'(art_pos);
                end
                else if (art_keys.size() >= tsk_pkg::ART_SLOTS)
                    res.status = tsk_pkg::ST_FULL;
                else
                begin
                    res.status = tsk_pkg::ST_ART_ADDED;
                    res.slot   = tsk_pkg::slot_t'(art_keys.size());
                    art_keys.push_back(key);
                end
            end
        end
        else if (art_pos >= 0 || none_pos >= 0)
            res.status = tsk_pkg::ST_IGNORED;
        else if (none_keys.size() >= tsk_pkg::NONE_ENTRIES)
            res.status = tsk_pkg::ST_FULL;
        else
        begin
            res.status = tsk_pkg::ST_NONE_ADDED;
            none_keys.push_back(key);
        end
        return res;
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is accepted.
    task automatic send_insert(input logic kind, input tsk_pkg::key_t key,
                               input tsk_pkg::stride_t plen);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= kind;
        req_ch.key_high     <= key[tsk_pkg::KEY_W-1:tsk_pkg::HALF_W];
        req_ch.key_low      <= key[tsk_pkg::HALF_W-1:0];
        req_ch.pixel_length <= plen;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        pending_outcomes.push_back(predict_insert(kind, key, plen));
        requests_sent++;
        recent_keys.push_back(key);
        if (recent_keys.size() > RECENT_DEPTH)
            void'(recent_keys.pop_front());
    endtask

    task automatic wait_idle(input int settle);
        req_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_stride(input tsk_pkg::stride_t value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        model_stride = value;
        stride_writes++;
    endtask

    // A mix of keys that hit one of the sets, recently sent keys, fresh keys and one-bit near misses.
    task automatic send_random_item();
        int               pick;
        int               len_pick;
        tsk_pkg::key_t    key;
        tsk_pkg::stride_t plen;
        pick = $urandom_range(0, 99);
        key  = fresh_key();
        if (pick < 20 && art_keys.size() > 0)
            key = art_keys[$urandom_range(0, art_keys.size() - 1)];
        else if (pick < 40 && none_keys.size() > 0)
            key = none_keys[$urandom_range(0, none_keys.size() - 1)];
        else if (pick < 55 && recent_keys.size() > 0)
            key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        else if (pick < 63 && art_keys.size() > 0)
            key = art_keys[$urandom_range(0, art_keys.size() - 1)]
                  ^ (tsk_pkg::key_t'(1) << $urandom_range(0, tsk_pkg::KEY_W - 1));
        else if (pick < 70 && none_keys.size() > 0)
            key = none_keys[$urandom_range(0, none_keys.size() - 1)]
                  ^ (tsk_pkg::key_t'(1) << $urandom_range(0, tsk_pkg::KEY_W - 1));
        if ($urandom_range(0, 1) == 1)
            send_insert(tsk_pkg::KIND_NONE, key, tsk_pkg::stride_t'($urandom));
        else
        begin
            len_pick = $urandom_range(0, 99);
            if (len_pick < 82)
                plen = model_stride;
            else if (len_pick < 88)
                plen = model_stride + 1'b1;
            else if (len_pick < 94)
                plen = model_stride - 1'b1;
            else
                plen = tsk_pkg::stride_t'($urandom);
            send_insert(tsk_pkg::KIND_ART, key, plen);
        end
    endtask

    task automatic test_directed_inserts();
        // Runs on the reset stride.
        send_insert(tsk_pkg::KIND_ART,  KEY_ZERO,      tsk_pkg::STRIDE_RESET);
        send_insert(tsk_pkg::KIND_ART,  KEY_ZERO,      tsk_pkg::STRIDE_RESET);
        send_insert(tsk_pkg::KIND_ART,  KEY_ONES,      tsk_pkg::STRIDE_RESET - 1'b1);
        send_insert(tsk_pkg::KIND_ART,  KEY_ONES,      '0);
        send_insert(tsk_pkg::KIND_ART,  KEY_ONES,      '1);
        send_insert(tsk_pkg::KIND_ART,  KEY_ONES,      tsk_pkg::STRIDE_RESET);
        send_insert(tsk_pkg::KIND_NONE, KEY_ZERO,      '0);
        send_insert(tsk_pkg::KIND_NONE, KEY_LOW_ONES,  '0);
        send_insert(tsk_pkg::KIND_NONE, KEY_LOW_ONES,  '1);
        send_insert(tsk_pkg::KIND_NONE, KEY_HIGH_ONES, '1);
        send_insert(tsk_pkg::KIND_NONE, KEY_BIT0,      tsk_pkg::STRIDE_RESET);
        // Removal from the middle of the no-art set must keep the order of the rest.
        send_insert(tsk_pkg::KIND_ART,  KEY_HIGH_ONES, tsk_pkg::STRIDE_RESET);
        send_insert(tsk_pkg::KIND_ART,  KEY_LOW_ONES,  tsk_pkg::STRIDE_RESET + 1'b1);
        send_insert(tsk_pkg::KIND_NONE, KEY_LOW_ONES,  '0);
        send_insert(tsk_pkg::KIND_ART,  KEY_LOW_ONES,  tsk_pkg::STRIDE_RESET);
        send_insert(tsk_pkg::KIND_ART,  KEY_BIT0,      tsk_pkg::STRIDE_RESET);
        send_insert(tsk_pkg::KIND_ART,  KEY_HIGH_ONES, tsk_pkg::STRIDE_RESET);
    endtask

    task automatic test_stride_extremes();
        wait_idle(8);
        write_stride(STRIDE_MIN);
        send_insert(tsk_pkg::KIND_ART, fresh_key(), STRIDE_MIN);
        send_insert(tsk_pkg::KIND_ART, fresh_key(), STRIDE_MIN - 1'b1);
        send_insert(tsk_pkg::KIND_ART, fresh_key(), STRIDE_MIN + 1'b1);
        wait_idle(8);
        write_stride(STRIDE_MAX);
        send_insert(tsk_pkg::KIND_ART, fresh_key(), STRIDE_MAX);
        send_insert(tsk_pkg::KIND_ART, fresh_key(), STRIDE_MAX - 1'b1);
        send_insert(tsk_pkg::KIND_ART, fresh_key(), STRIDE_MAX + 1'b1);
        send_insert(tsk_pkg::KIND_ART, fresh_key(), '1);
    endtask

    task automatic test_random_mix();
        int phase;
        int n;
        for (phase = 0; phase < MIX_PHASES; phase++)
        begin
            wait_idle(8);
            write_stride(tsk_pkg::stride_t'($urandom_range(3, 786432)));
            send_gap_max = (phase == 0 || phase == 2) ? GAP_LIMIT : 0;
            recv_gap_max = (phase == 0 || phase == 3) ? GAP_LIMIT : 0;
            for (n = 0; n < MIX_ITEMS; n++)
            begin
                // Now and then the sender holds off until the block has drained.
                if ($urandom_range(0, 59) == 0)
                    wait_idle(0);
                send_random_item();
            end
        end
        send_gap_max = GAP_LIMIT;
        recv_gap_max = GAP_LIMIT;
    endtask

    task automatic test_fill_to_capacity();
        tsk_pkg::key_t moved;
        wait_idle(8);
        write_stride(tsk_pkg::stride_t'($urandom_range(3, 786432)));
        while (none_keys.size() < tsk_pkg::NONE_ENTRIES)
            send_insert(tsk_pkg::KIND_NONE, fresh_key(), tsk_pkg::stride_t'($urandom));
        send_insert(tsk_pkg::KIND_NONE, fresh_key(), tsk_pkg::stride_t'($urandom));
        send_insert(tsk_pkg::KIND_NONE, none_keys[0], tsk_pkg::stride_t'($urandom));
        while (art_keys.size() < tsk_pkg::ART_SLOTS)
            send_insert(tsk_pkg::KIND_ART, fresh_key(), model_stride);
        send_insert(tsk_pkg::KIND_ART, fresh_key(), model_stride);
        // A full art set still takes the key out of the no-art set.
        moved = none_keys[$urandom_range(0, tsk_pkg::NONE_ENTRIES - 1)];
        send_insert(tsk_pkg::KIND_ART, moved, model_stride);
        send_insert(tsk_pkg::KIND_NONE, moved, tsk_pkg::stride_t'($urandom));
        send_insert(tsk_pkg::KIND_ART, art_keys[tsk_pkg::ART_SLOTS - 1], model_stride);
    endtask

    task automatic test_random_tail();
        wait_idle(8);
        write_stride(tsk_pkg::stride_t'($urandom_range(3, 786432)));
        while (requests_sent < TARGET_ITEMS)
            send_random_item();
    endtask

    initial
    begin : result_checker
        outcome_t want;
        int       stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = $urandom_range(0, recv_gap_max);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
            status_seen[rsp_ch.status]++;
            if (rsp_ch.left_no_art === 1'b1)
                left_count++;
            if (pending_outcomes.size() == 0)
            begin
                error_count++;
                $display("%0t: transaction with no request pending: status %0d slot %0d left %0b",
                         $time, rsp_ch.status, rsp_ch.slot, rsp_ch.left_no_art);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    error_count++;
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, rsp_ch.status);
                end
                if (rsp_ch.slot !== want.slot)
                begin
                    error_count++;
                    $display("%0t: slot mismatch, expected %0d, got %0d",
                             $time, want.slot, rsp_ch.slot);
                end
                if (rsp_ch.left_no_art !== want.left_no_art)
                begin
                    error_count++;
                    $display("%0t: left_no_art mismatch, expected %0b, got %0b",
                             $time, want.left_no_art, rsp_ch.left_no_art);
                end
            end
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        req_ch.valid        = 1'b0;
        req_ch.kind         = tsk_pkg::KIND_ART;
        req_ch.key_high     = '0;
        req_ch.key_low      = '0;
        req_ch.pixel_length = '0;
        model_stride        = tsk_pkg::STRIDE_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_inserts();
        test_stride_extremes();
        test_random_mix();
        test_fill_to_capacity();
        test_random_tail();
        wait_idle(SETTLE_CYCLES);

        $display("Ran %0d insert transactions over %0d stride settings:",
                 requests_sent, stride_writes);
        $display("%0d art added, %0d updated, %0d no-art added, %0d ignored,",
                 status_seen[tsk_pkg::ST_ART_ADDED], status_seen[tsk_pkg::ST_ART_UPDATED],
                 status_seen[tsk_pkg::ST_NONE_ADDED], status_seen[tsk_pkg::ST_IGNORED]);
        $display("%0d bad length, %0d table full, %0d keys moved out of the no-art set.",
                 status_seen[tsk_pkg::ST_BAD_LENGTH], status_seen[tsk_pkg::ST_FULL],
                 left_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout: %0d results still pending", pending_outcomes.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/tsk_pkg.sv
hdl/tsk_req_if.sv
hdl/tsk_rsp_if.sv
hdl/tsk_ram.sv
hdl/two_set_key_table_insert_top.sv
tb/testbench.sv
